FILE: hw/rtl/sds_pkg.sv
// sds_pkg: shared constants for the stick dead-zone shaper
// mode codes, register indexes and fixed-point widths
// no dependencies
`default_nettype none
package sds_pkg;

   // fixed point: magnitudes carry 16 fractional bits
   localparam int FRAC_BITS = 16;
   localparam int MAG_BITS = FRAC_BITS + 1;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // dead-zone mode codes
   localparam logic [2:0] MODE_AXIAL         = 3'd0;
   localparam logic [2:0] MODE_RADIAL        = 3'd1;
   localparam logic [2:0] MODE_SCALED_RADIAL = 3'd2;
   localparam logic [2:0] MODE_SLOPED_AXIAL  = 3'd3;
   localparam logic [2:0] MODE_SLOPED_SCALED = 3'd4;
   localparam logic [2:0] MODE_HYBRID        = 3'd5;

   // register indexes on the csr port
   localparam logic [1:0] CSR_MODE     = 2'd0;
   localparam logic [1:0] CSR_DEADZONE = 2'd1;
   localparam logic [1:0] CSR_SCALE    = 2'd2;

   // register reset values
   localparam logic [9:0] SCALE_RESET = 10'd16;

endpackage
`default_nettype wire

FILE: hw/rtl/sds_sqrt.sv
// sds_sqrt: pipelined integer square root, one result bit per stage
// floor(sqrt(in_rad)) with a sideband carried alongside; no package use
`default_nettype none
module sds_sqrt #(
   parameter int RADW = 34,
   parameter int SW = 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [RADW-1:0]     in_rad,
   input  wire logic [SW-1:0]       in_side,
   output logic                     out_valid,
   output logic [RADW/2-1:0]        out_root,
   output logic [SW-1:0]            out_side
);

   localparam int QW = RADW / 2;
   localparam int RW = QW + 3;

   logic            valid_c [QW+1];
   logic [RADW-1:0] rad_c   [QW+1];
   logic [RW-1:0]   rem_c   [QW+1];
   logic [QW-1:0]   root_c  [QW+1];
   logic [SW-1:0]   side_c  [QW+1];

   assign valid_c[0] = in_valid;
   assign rad_c[0]   = in_rad;
   assign rem_c[0]   = '0;
   assign root_c[0]  = '0;
   assign side_c[0]  = in_side;

   for (genvar k = 0; k < QW; k++) begin : stage
      logic            valid_ff;
      logic [RADW-1:0] rad_ff, rad_in;
      logic [RW-1:0]   rem_ff, rem_in;
      logic [QW-1:0]   root_ff, root_in;
      logic [SW-1:0]   side_ff;
      logic [RW-1:0]   shifted;
      logic [RW-1:0]   trial;
      logic            take;

      // bring down two radicand bits and try appending a one
      always_comb begin
         shifted = {rem_c[k][RW-3:0], rad_c[k][RADW-1 -: 2]};
         trial   = RW'({root_c[k], 2'b01});
         take    = shifted >= trial;
         rem_in  = take ? shifted - trial : shifted;
         root_in = {root_c[k][QW-2:0], take};
         rad_in  = rad_c[k] << 2;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_c[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff  <= rad_in;
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= side_c[k];
         end
      end

      assign valid_c[k+1] = valid_ff;
      assign rad_c[k+1]   = rad_ff;
      assign rem_c[k+1]   = rem_ff;
      assign root_c[k+1]  = root_ff;
      assign side_c[k+1]  = side_ff;
   end

   assign out_valid = valid_c[QW];
   assign out_root  = root_c[QW];
   assign out_side  = side_c[QW];

endmodule
`default_nettype wire

FILE: hw/rtl/sds_div.sv
// sds_div: pipelined restoring divider, one quotient bit per stage
// requires in_num < in_den * 2^QW; sideband carried alongside; no package use
`default_nettype none
module sds_div #(
   parameter int NW = 33,
   parameter int DW = 17,
   parameter int QW = 32,
   parameter int SW = 1
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            in_valid,
   input  wire logic [NW-1:0]   in_num,
   input  wire logic [DW-1:0]   in_den,
   input  wire logic [SW-1:0]   in_side,
   output logic                 out_valid,
   output logic [QW-1:0]        out_quo,
   output logic [SW-1:0]        out_side
);

   localparam int CW = NW + DW + QW;

   logic          valid_c [QW+1];
   logic [NW-1:0] rem_c   [QW+1];
   logic [DW-1:0] den_c   [QW+1];
   logic [QW-1:0] quo_c   [QW+1];
   logic [SW-1:0] side_c  [QW+1];

   assign valid_c[0] = in_valid;
   assign rem_c[0]   = in_num;
   assign den_c[0]   = in_den;
   assign quo_c[0]   = '0;
   assign side_c[0]  = in_side;

   for (genvar k = 0; k < QW; k++) begin : stage
      logic          valid_ff;
      logic [NW-1:0] rem_ff, rem_in;
      logic [DW-1:0] den_ff;
      logic [QW-1:0] quo_ff, quo_in;
      logic [SW-1:0] side_ff;
      logic [CW-1:0] trial;
      logic          take;

      // subtract the shifted divisor where it fits
      always_comb begin
         trial  = CW'(den_c[k]) << (QW - 1 - k);
         take   = CW'(rem_c[k]) >= trial;
         rem_in = take ? NW'(CW'(rem_c[k]) - trial) : rem_c[k];
         quo_in = quo_c[k];
         quo_in[QW-1-k] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_c[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            den_ff  <= den_c[k];
            quo_ff  <= quo_in;
            side_ff <= side_c[k];
         end
      end

      assign valid_c[k+1] = valid_ff;
      assign rem_c[k+1]   = rem_ff;
      assign den_c[k+1]   = den_ff;
      assign quo_c[k+1]   = quo_ff;
      assign side_c[k+1]  = side_ff;
   end

   assign out_valid = valid_c[QW];
   assign out_quo   = quo_c[QW];
   assign out_side  = side_c[QW];

endmodule
`default_nettype wire

FILE: hw/rtl/stick_deadzone_shaper.sv
// stick_deadzone_shaper: dead-zone shaping of a stick sample into pointer deltas
// path from req to rsp: square root (17 stages), two 32-stage dividers, one 17-stage
// divider, 12 stages of glue and multipliers
// throughput: one transaction per cycle while rsp is ready; an output skid register
// takes the result held up by an rsp stall, and req_tready drops while it holds one
// reset: synchronous, active high; clears valid bits and loads register defaults
// depends on sds_pkg, sds_sqrt, sds_div
`default_nettype none
module stick_deadzone_shaper #(
   parameter int SAMPLE_BITS = sds_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // stick_x [15:0], stick_y [31:16]
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // pointer_dx [10:0], pointer_dy [21:11], zero pad
   // configuration writes
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_wdata
);

   localparam int MB = sds_pkg::MAG_BITS;
   localparam int FB = sds_pkg::FRAC_BITS;
   localparam int SHIFT = MB - SAMPLE_BITS;
   localparam logic [MB-1:0] ONE = MB'(1) << FB;

   // configuration registers
   logic [2:0]  mode_ff;
   logic [14:0] dz_level_ff;
   logic [9:0]  scale_ff;
   logic [15:0] dz;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= sds_pkg::MODE_AXIAL;
         dz_level_ff <= '0;
         scale_ff    <= sds_pkg::SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            sds_pkg::CSR_MODE:     mode_ff     <= csr_wdata[2:0];
            sds_pkg::CSR_DEADZONE: dz_level_ff <= csr_wdata;
            sds_pkg::CSR_SCALE:    scale_ff    <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   assign dz = {dz_level_ff, 1'b0};

   // pipeline advance: frozen only while the skid register holds a result
   logic en;
   logic skid_v_ff;
   assign en = !skid_v_ff;
   assign req_tready = en;

   // stage 1: sign and magnitude of each axis
   logic [SAMPLE_BITS-1:0] raw_x, raw_y;
   logic [SAMPLE_BITS:0]   m_x, m_y;
   logic                   v1_ff;
   logic                   nx1_ff, ny1_ff;
   logic [MB-1:0]          ax1_ff, ay1_ff;

   always_comb begin
      raw_x = req_tdata[SAMPLE_BITS-1:0];
      raw_y = req_tdata[16 +: SAMPLE_BITS];
      m_x = raw_x[SAMPLE_BITS-1] ? {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, raw_x}
                                 : {1'b0, raw_x};
      m_y = raw_y[SAMPLE_BITS-1] ? {1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, raw_y}
                                 : {1'b0, raw_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx1_ff <= raw_x[SAMPLE_BITS-1];
         ny1_ff <= raw_y[SAMPLE_BITS-1];
         ax1_ff <= MB'(m_x) << SHIFT;
         ay1_ff <= MB'(m_y) << SHIFT;
      end
   end

   // stage 2: squares and sloped thresholds
   logic        v2_ff;
   logic        nx2_ff, ny2_ff;
   logic [16:0] ax2_ff, ay2_ff;
   logic [33:0] sqx2_ff, sqy2_ff;
   logic [31:0] dzsq2_ff;
   logic [15:0] tx2_ff, ty2_ff;
   logic [32:0] slx_prod, sly_prod;

   assign slx_prod = {17'd0, dz} * {16'd0, ay1_ff};
   assign sly_prod = {17'd0, dz} * {16'd0, ax1_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx2_ff   <= nx1_ff;
         ny2_ff   <= ny1_ff;
         ax2_ff   <= ax1_ff;
         ay2_ff   <= ay1_ff;
         sqx2_ff  <= {17'd0, ax1_ff} * {17'd0, ax1_ff};
         sqy2_ff  <= {17'd0, ay1_ff} * {17'd0, ay1_ff};
         dzsq2_ff <= {16'd0, dz} * {16'd0, dz};
         tx2_ff   <= slx_prod[31:16];
         ty2_ff   <= sly_prod[31:16];
      end
   end

   // stage 3: radius squared, radial test, results of the simple modes
   logic        v3_ff;
   logic [33:0] s2sum;
   logic        ok_in;
   logic [16:0] sx_in, sy_in;
   logic [70:0] side3_ff;
   logic [33:0] rad3_ff;

   always_comb begin
      s2sum = sqx2_ff + sqy2_ff;
      ok_in = (s2sum >= {2'd0, dzsq2_ff}) && (s2sum != '0);
      unique case (mode_ff)
         sds_pkg::MODE_RADIAL: begin
            sx_in = (s2sum >= {2'd0, dzsq2_ff}) ? ax2_ff : '0;
            sy_in = (s2sum >= {2'd0, dzsq2_ff}) ? ay2_ff : '0;
         end
         sds_pkg::MODE_SLOPED_AXIAL: begin
            sx_in = (ax2_ff < {1'b0, tx2_ff}) ? '0 : ax2_ff;
            sy_in = (ay2_ff < {1'b0, ty2_ff}) ? '0 : ay2_ff;
         end
         default: begin
            sx_in = (ax2_ff > {1'b0, dz}) ? ax2_ff : '0;
            sy_in = (ay2_ff > {1'b0, dz}) ? ay2_ff : '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad3_ff  <= s2sum;
         side3_ff <= {nx2_ff, ny2_ff, ax2_ff, ay2_ff, sx_in, sy_in, ok_in};
      end
   end

   // radius by square root
   logic        vq_out;
   logic [16:0] mag_out;
   logic [70:0] sideq_out;

   sds_sqrt #(
      .RADW (34),
      .SW   (71)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_rad    (rad3_ff),
      .in_side   (side3_ff),
      .out_valid (vq_out),
      .out_root  (mag_out),
      .out_side  (sideq_out)
   );

   // stage 4: remap numerator and denominator for the scaled radius
   logic        v4_ff;
   logic [32:0] num4_ff;
   logic [16:0] den4_ff;
   logic [87:0] side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= vq_out;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num4_ff  <= sideq_out[0] ? {mag_out - {1'b0, dz}, 16'd0} : '0;
         den4_ff  <= ONE - {1'b0, dz};
         side4_ff <= {sideq_out, mag_out};
      end
   end

   // scaled radius r
   logic        vr_out;
   logic [31:0] r_out;
   logic [87:0] sider_out;

   sds_div #(
      .NW (33),
      .DW (17),
      .QW (32),
      .SW (88)
   ) u_div_radius (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_num    (num4_ff),
      .in_den    (den4_ff),
      .in_side   (side4_ff),
      .out_valid (vr_out),
      .out_quo   (r_out),
      .out_side  (sider_out)
   );

   // stage 5: partial products of a * r
   logic [16:0] ax_r, ay_r;
   logic        v5_ff;
   logic [32:0] pxl5_ff, pxh5_ff, pyl5_ff, pyh5_ff;
   logic [87:0] side5_ff;

   assign ax_r = sider_out[85:69];
   assign ay_r = sider_out[68:52];

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= vr_out;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pxl5_ff  <= {16'd0, ax_r} * {17'd0, r_out[15:0]};
         pxh5_ff  <= {16'd0, ax_r} * {17'd0, r_out[31:16]};
         pyl5_ff  <= {16'd0, ay_r} * {17'd0, r_out[15:0]};
         pyh5_ff  <= {16'd0, ay_r} * {17'd0, r_out[31:16]};
         side5_ff <= sider_out;
      end
   end

   // stage 6: sum of partial products
   logic        v6_ff;
   logic [48:0] numx6_ff, numy6_ff;
   logic [16:0] mag6_ff;
   logic [70:0] side6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         numx6_ff <= {pxh5_ff, 16'd0} + {16'd0, pxl5_ff};
         numy6_ff <= {pyh5_ff, 16'd0} + {16'd0, pyl5_ff};
         mag6_ff  <= side5_ff[16:0];
         side6_ff <= side5_ff[87:17];
      end
   end

   // per-axis a * r / mag
   logic        vdx_out;
   logic [31:0] qx_out, qy_out;
   logic [70:0] sidex_out;
   logic        oky_out;

   sds_div #(
      .NW (49),
      .DW (17),
      .QW (32),
      .SW (71)
   ) u_div_axis_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v6_ff),
      .in_num    (numx6_ff),
      .in_den    (mag6_ff),
      .in_side   (side6_ff),
      .out_valid (vdx_out),
      .out_quo   (qx_out),
      .out_side  (sidex_out)
   );

   sds_div #(
      .NW (49),
      .DW (17),
      .QW (32),
      .SW (1)
   ) u_div_axis_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v6_ff),
      .in_num    (numy6_ff),
      .in_den    (mag6_ff),
      .in_side   (side6_ff[0]),
      .out_valid (),
      .out_quo   (qy_out),
      .out_side  (oky_out)
   );

   // stage 7: scaled radial result and inputs of the sloped scaled stage
   logic [31:0] gx, gy;
   logic        v7_ff;
   logic [16:0] sax7_ff, say7_ff;
   logic [31:0] v2x7_ff, v2y7_ff;
   logic [35:0] side7_ff;

   assign gx = sidex_out[0] ? qx_out : '0;
   assign gy = oky_out ? qy_out : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= vdx_out;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (mode_ff == sds_pkg::MODE_HYBRID) begin
            sax7_ff <= (gx > 32'(ONE)) ? ONE : gx[16:0];
            say7_ff <= (gy > 32'(ONE)) ? ONE : gy[16:0];
         end else begin
            sax7_ff <= sidex_out[70 - 2 -: 17];
            say7_ff <= sidex_out[70 - 19 -: 17];
         end
         v2x7_ff  <= gx;
         v2y7_ff  <= gy;
         side7_ff <= {sidex_out[70:69], sidex_out[34:1]};
      end
   end

   // stage 8: sloped thresholds from the other axis
   logic [32:0] tpx, tpy;
   logic        v8_ff;
   logic [16:0] sax8_ff, say8_ff;
   logic [15:0] tx8_ff, ty8_ff;
   logic [99:0] side8_ff;

   assign tpx = {17'd0, dz} * {16'd0, say7_ff};
   assign tpy = {17'd0, dz} * {16'd0, sax7_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sax8_ff  <= sax7_ff;
         say8_ff  <= say7_ff;
         tx8_ff   <= tpx[31:16];
         ty8_ff   <= tpy[31:16];
         side8_ff <= {side7_ff, v2x7_ff, v2y7_ff};
      end
   end

   // stage 9: sloped scaled numerators and denominators
   logic        v9_ff;
   logic [32:0] num9x_ff, num9y_ff;
   logic [16:0] den9x_ff, den9y_ff;
   logic [99:0] side9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (en) begin
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num9x_ff <= (sax8_ff > {1'b0, tx8_ff}) ? {sax8_ff - {1'b0, tx8_ff}, 16'd0} : '0;
         num9y_ff <= (say8_ff > {1'b0, ty8_ff}) ? {say8_ff - {1'b0, ty8_ff}, 16'd0} : '0;
         den9x_ff <= ONE - {1'b0, tx8_ff};
         den9y_ff <= ONE - {1'b0, ty8_ff};
         side9_ff <= side8_ff;
      end
   end

   // sloped scaled quotients
   logic        vs_out;
   logic [16:0] q3x_out, q3y_out;
   logic [99:0] sides_out;
   logic        ny_s;

   sds_div #(
      .NW (33),
      .DW (17),
      .QW (17),
      .SW (100)
   ) u_div_slope_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v9_ff),
      .in_num    (num9x_ff),
      .in_den    (den9x_ff),
      .in_side   (side9_ff),
      .out_valid (vs_out),
      .out_quo   (q3x_out),
      .out_side  (sides_out)
   );

   sds_div #(
      .NW (33),
      .DW (17),
      .QW (17),
      .SW (1)
   ) u_div_slope_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v9_ff),
      .in_num    (num9y_ff),
      .in_den    (den9y_ff),
      .in_side   (side9_ff[98]),
      .out_valid (),
      .out_quo   (q3y_out),
      .out_side  (ny_s)
   );

   // stage 10: pick the result of the selected mode and clamp
   logic [31:0] selx, sely;
   logic [16:0] sx_s, sy_s;
   logic [31:0] v2x_s, v2y_s;
   logic        v10_ff;
   logic        nx10_ff, ny10_ff;
   logic [26:0] vx10_ff, vy10_ff;
   localparam logic [31:0] CLAMP = 32'd1 << 26;

   assign sx_s  = sides_out[97:81];
   assign sy_s  = sides_out[80:64];
   assign v2x_s = sides_out[63:32];
   assign v2y_s = sides_out[31:0];

   always_comb begin
      unique case (mode_ff)
         sds_pkg::MODE_SCALED_RADIAL: begin
            selx = v2x_s;
            sely = v2y_s;
         end
         sds_pkg::MODE_SLOPED_SCALED, sds_pkg::MODE_HYBRID: begin
            selx = 32'(q3x_out);
            sely = 32'(q3y_out);
         end
         default: begin
            selx = 32'(sx_s);
            sely = 32'(sy_s);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else if (en) begin
         v10_ff <= vs_out;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx10_ff <= sides_out[99];
         ny10_ff <= ny_s;
         vx10_ff <= (selx > CLAMP) ? CLAMP[26:0] : selx[26:0];
         vy10_ff <= (sely > CLAMP) ? CLAMP[26:0] : sely[26:0];
      end
   end

   // stage 11: output scale
   logic        v11_ff;
   logic        nx11_ff, ny11_ff;
   logic [36:0] px11_ff, py11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
      end else if (en) begin
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nx11_ff <= nx10_ff;
         ny11_ff <= ny10_ff;
         px11_ff <= {10'd0, vx10_ff} * {27'd0, scale_ff};
         py11_ff <= {10'd0, vy10_ff} * {27'd0, scale_ff};
      end
   end

   // stage 12: saturate and apply sign
   logic [20:0] mx, my;
   logic [9:0]  satx, saty;
   logic        out_v_ff;
   logic [10:0] dx_ff, dy_ff;

   always_comb begin
      mx = px11_ff[36:16];
      my = py11_ff[36:16];
      satx = (mx > 21'd1023) ? 10'd1023 : mx[9:0];
      saty = (my > 21'd1023) ? 10'd1023 : my[9:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= v11_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= nx11_ff ? 11'd0 - {1'b0, satx} : {1'b0, satx};
         dy_ff <= ny11_ff ? 11'd0 - {1'b0, saty} : {1'b0, saty};
      end
   end

   // output skid register
   logic [10:0] skid_dx_ff, skid_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_tready) begin
            skid_v_ff <= 1'b0;
         end
      end else if (out_v_ff && !rsp_tready) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_v_ff) begin
         skid_dx_ff <= dx_ff;
         skid_dy_ff <= dy_ff;
      end
   end

   assign rsp_tvalid = skid_v_ff || out_v_ff;
   assign rsp_tdata  = skid_v_ff ? {2'b00, skid_dy_ff, skid_dx_ff}
                                 : {2'b00, dy_ff, dx_ff};

endmodule
`default_nettype wire
